@@ rtl/core/pem_pkg.sv @@
// Shared types, constants and register codes of the Prewitt edge magnitude block.
package pem_pkg;

	localparam int CFG_W      = 11;
	localparam int KSIZE_W    = 3;
	localparam int REG_IDX_W  = 2;
	localparam int CHAN_W     = 8;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_KERNEL = 7;

	localparam logic [CFG_W-1:0]   RESET_FRAME_WIDTH  = 11'd640;
	localparam logic [CFG_W-1:0]   RESET_FRAME_HEIGHT = 11'd480;
	localparam logic [KSIZE_W-1:0] RESET_KERNEL_SIZE  = 3'd3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_KERNEL_SIZE  = 2'd2
	} reg_idx_t;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pix_t;

	typedef struct packed {
		logic take;
		logic wr_en;
		logic adv_skip;
		logic adv_out;
		logic rd_start;
		logic rd_step;
		logic sq_square;
		logic sq_sum;
		logic sq_step;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_frame;
		logic flush;
		logic has_out;
		logic rd_last;
		logic pipe_busy;
		logic root_last;
		logic out_free;
	} dp_stat_t;

endpackage

@@ rtl/core/pem_if.sv @@
// Valid/ready channel interfaces for pixel input and magnitude output.
interface pem_in_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [pem_pkg::CHAN_W-1:0]    in_blue;
	logic [pem_pkg::CHAN_W-1:0]    in_green;
	logic [pem_pkg::CHAN_W-1:0]    in_red;

	modport source (output valid, cmd, in_blue, in_green, in_red, input ready);
	modport sink (input valid, cmd, in_blue, in_green, in_red, output ready);
endinterface

interface pem_out_if;
	logic                          valid;
	logic                          ready;
	logic [pem_pkg::CHAN_W-1:0]    out_blue;
	logic [pem_pkg::CHAN_W-1:0]    out_green;
	logic [pem_pkg::CHAN_W-1:0]    out_red;
	logic                          frame_last;

	modport source (output valid, out_blue, out_green, out_red, frame_last, input ready);
	modport sink (input valid, out_blue, out_green, out_red, frame_last, output ready);
endinterface

@@ rtl/core/prewitt_edge_magnitude_rgb.sv @@
// Top level of the RGB Prewitt edge magnitude block.
//
//  channel     | role   | transaction
//  ------------+--------+---------------------------------------------------
//  pixels      | sink   | cmd, in_blue, in_green, in_red on valid & ready
//  magnitudes  | source | out_blue, out_green, out_red, frame_last
//  cfg         | write  | cfg_index, cfg_data on cfg_wen
//
// A transaction that yields a result is bounded by the single read port of the line
// store (one window sample per cycle, then a drain of the read pipeline) and the
// bit-serial square root (8 steps).
// Reset clears configuration to 640 x 480, K = 3, and starts a new frame; the line
// store needs no clearing. A held result stalls the next result, and input waits with it.
module prewitt_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = pem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pem_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_KERNEL = pem_pkg::DEF_MAX_KERNEL
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [pem_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [pem_pkg::CFG_W-1:0]     cfg_data,
	pem_in_if.sink                        pixels,
	pem_out_if.source                     magnitudes
);

	pem_pkg::ctrl_cmd_t cmd;
	pem_pkg::dp_stat_t  st;
	pem_pkg::pix_t      item_pix;

	assign item_pix.red   = pixels.in_red;
	assign item_pix.green = pixels.in_green;
	assign item_pix.blue  = pixels.in_blue;

	pem_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.in_ready (pixels.ready),
		.st       (st),
		.cmd      (cmd)
	);

	pem_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_KERNEL (MAX_KERNEL)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.item_cmd   (pixels.cmd),
		.item_pix   (item_pix),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (magnitudes.valid),
		.out_ready  (magnitudes.ready),
		.out_blue   (magnitudes.out_blue),
		.out_green  (magnitudes.out_green),
		.out_red    (magnitudes.out_red),
		.frame_last (magnitudes.frame_last)
	);

	a_store_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (st.in_frame && !st.flush))
		else $error("line store written outside the frame or on a flush");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("result loaded over an untaken result");

	a_accept_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.ready) |-> !st.pipe_busy)
		else $error("transaction accepted while window reads in flight");

	a_read_then_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_step && st.rd_last) |=> !cmd.rd_step)
		else $error("window read sequence ran past its last sample");

endmodule

@@ rtl/core/pem_ram.sv @@
// Generic simple dual-port RAM with registered read.
module pem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 7168
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/pem_ctrl.sv @@
// Controller state machine sequencing accept, store write, window reads, root and output.
module pem_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pem_pkg::dp_stat_t  st,
	output pem_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_READ   = 8'b0000_0100,
		S_DRAIN  = 8'b0000_1000,
		S_SQUARE = 8'b0001_0000,
		S_SUM    = 8'b0010_0000,
		S_ROOT   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (st.in_frame && st.flush) begin
					state_d = S_IDLE;
				end else begin
					cmd.wr_en = st.in_frame;
					if (!st.has_out) begin
						cmd.adv_skip = 1'b1;
						state_d      = S_IDLE;
					end else begin
						cmd.rd_start = 1'b1;
						state_d      = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.rd_step = 1'b1;
				if (st.rd_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!st.pipe_busy) begin
					state_d = S_SQUARE;
				end
			end
			S_SQUARE: begin
				cmd.sq_square = 1'b1;
				state_d       = S_SUM;
			end
			S_SUM: begin
				cmd.sq_sum = 1'b1;
				state_d    = S_ROOT;
			end
			S_ROOT: begin
				cmd.sq_step = 1'b1;
				if (st.root_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.adv_out  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/pem_dp.sv @@
// Datapath: config registers, frame counters, line store addressing, kernel sums and square root.
module pem_dp #(
	parameter int MAX_WIDTH  = pem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pem_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_KERNEL = pem_pkg::DEF_MAX_KERNEL
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [pem_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [pem_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             item_cmd,
	input  pem_pkg::pix_t                    item_pix,
	input  pem_pkg::ctrl_cmd_t               cmd,
	output pem_pkg::dp_stat_t                st,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pem_pkg::CHAN_W-1:0]       out_blue,
	output logic [pem_pkg::CHAN_W-1:0]       out_green,
	output logic [pem_pkg::CHAN_W-1:0]       out_red,
	output logic                             frame_last
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_KERNEL + 1);
	localparam int NW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_KERNEL * MAX_WIDTH + 1);
	localparam int PW    = WW + HW;
	localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CDW   = ((WW > HW) ? WW : HW) + 2;
	localparam int GW    = $clog2(MAX_KERNEL * 255 + 1) + 1;
	localparam int MW    = 2 * (GW - 1);
	localparam int CW    = pem_pkg::CHAN_W;

	logic [pem_pkg::CFG_W-1:0]   width_q, height_q;
	logic [pem_pkg::KSIZE_W-1:0] ksize_q;

	logic [WW-1:0] w_eff_q, w_eff;
	logic [HW-1:0] h_eff_q, h_eff;
	logic [RW-1:0] r_eff_q, r_eff;
	logic [NW-1:0] total_q, delay_q;
	int            k_int;

	logic [NW-1:0] n_q;
	logic [AW-1:0] wp_q;
	logic [HW-1:0] oi_q;
	logic [WW-1:0] oj_q;
	logic          last_pix;
	logic          col_end;

	logic          flush_q;
	pem_pkg::pix_t pix_q;

	logic [1:0]           seg_q;
	logic signed [RW:0]   t_q;
	logic signed [RW:0]   r_sig;

	logic signed [CDW-1:0] row_c, col_c, i_c, j_c, t_c, r_c, hmax_c, wmax_c;
	logic                  neg_c, gy_c;

	logic [HW-1:0] row_s1;
	logic [WW-1:0] col_s1;
	logic [PW-1:0] p_s2;
	logic [AW-1:0] d_s3;
	logic [AW:0]   raddr_w;
	logic [AW-1:0] raddr;
	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic          neg_s1, neg_s2, neg_s3, neg_s4;
	logic          gy_s1, gy_s2, gy_s3, gy_s4;
	pem_pkg::pix_t rdata;

	logic signed [GW-1:0] gx_q [3];
	logic signed [GW-1:0] gy_q [3];
	logic [MW-1:0]        sqx_q [3];
	logic [MW-1:0]        sqy_q [3];
	logic [15:0]          s_q [3];
	logic [2:0]           sat_q;
	logic [CW-1:0]        root_q [3];
	logic [2:0]           bit_q;

	logic          out_vld_q;
	logic [CW-1:0] ob_q, og_q, or_q;
	logic          olast_q;

	// effective geometry
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
		k_int = int'(ksize_q);
		if (k_int > MAX_KERNEL) begin
			k_int = MAX_KERNEL;
		end
		if (k_int[0] == 1'b0) begin
			k_int = (k_int == 0) ? 0 : k_int - 1;
		end
		if (k_int < 3) begin
			k_int = 3;
		end
		r_eff = RW'((k_int - 1) >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pem_pkg::RESET_FRAME_WIDTH;
			height_q <= pem_pkg::RESET_FRAME_HEIGHT;
			ksize_q  <= pem_pkg::RESET_KERNEL_SIZE;
			w_eff_q  <= '0;
			h_eff_q  <= '0;
			r_eff_q  <= '0;
			total_q  <= '0;
			delay_q  <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					pem_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data;
					pem_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
					pem_pkg::REG_KERNEL_SIZE:  ksize_q  <= cfg_data[pem_pkg::KSIZE_W-1:0];
					default: ;
				endcase
			end
			w_eff_q <= w_eff;
			h_eff_q <= h_eff;
			r_eff_q <= r_eff;
			total_q <= NW'(w_eff * h_eff);
			delay_q <= NW'(r_eff * w_eff) + NW'(r_eff);
		end
	end

	// frame counters
	assign col_end  = (oj_q == w_eff_q - WW'(1));
	assign last_pix = col_end && (oi_q == h_eff_q - HW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q  <= '0;
			wp_q <= '0;
			oi_q <= '0;
			oj_q <= '0;
		end else if (cfg_wen && (cfg_index == pem_pkg::REG_FRAME_WIDTH ||
				cfg_index == pem_pkg::REG_FRAME_HEIGHT ||
				cfg_index == pem_pkg::REG_KERNEL_SIZE)) begin
			n_q  <= '0;
			wp_q <= '0;
			oi_q <= '0;
			oj_q <= '0;
		end else if (cmd.adv_out && last_pix) begin
			n_q  <= '0;
			wp_q <= '0;
			oi_q <= '0;
			oj_q <= '0;
		end else if (cmd.adv_skip || cmd.adv_out) begin
			n_q  <= n_q + NW'(1);
			wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (cmd.adv_out) begin
				oj_q <= col_end ? '0 : oj_q + WW'(1);
				oi_q <= col_end ? oi_q + HW'(1) : oi_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			flush_q <= (item_cmd == pem_pkg::CMD_FLUSH);
			pix_q   <= item_pix;
		end
	end

	// window read sequence
	assign r_sig = signed'({1'b0, r_eff_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
			t_q   <= '0;
		end else if (cmd.rd_start) begin
			seg_q <= '0;
			t_q   <= -r_sig;
		end else if (cmd.rd_step) begin
			if (t_q == r_sig) begin
				t_q   <= -r_sig;
				seg_q <= seg_q + 2'd1;
			end else begin
				t_q <= t_q + (RW+1)'(1);
			end
		end
	end

	always_comb begin
		i_c    = signed'(CDW'(oi_q));
		j_c    = signed'(CDW'(oj_q));
		t_c    = CDW'(t_q);
		r_c    = signed'(CDW'(r_eff_q));
		hmax_c = signed'(CDW'(h_eff_q)) - CDW'(1);
		wmax_c = signed'(CDW'(w_eff_q)) - CDW'(1);
		unique case (seg_q)
			2'd0: begin row_c = i_c + t_c; col_c = j_c + r_c; neg_c = 1'b0; gy_c = 1'b0; end
			2'd1: begin row_c = i_c + t_c; col_c = j_c - r_c; neg_c = 1'b1; gy_c = 1'b0; end
			2'd2: begin row_c = i_c + r_c; col_c = j_c + t_c; neg_c = 1'b0; gy_c = 1'b1; end
			2'd3: begin row_c = i_c - r_c; col_c = j_c + t_c; neg_c = 1'b1; gy_c = 1'b1; end
			default: begin row_c = i_c; col_c = j_c; neg_c = 1'b0; gy_c = 1'b0; end
		endcase
		if (row_c < 0) begin
			row_c = '0;
		end else if (row_c > hmax_c) begin
			row_c = hmax_c;
		end
		if (col_c < 0) begin
			col_c = '0;
		end else if (col_c > wmax_c) begin
			col_c = wmax_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_step;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= HW'(row_c);
		col_s1 <= WW'(col_c);
		neg_s1 <= neg_c;
		gy_s1  <= gy_c;
		p_s2   <= PW'(row_s1 * w_eff_q) + PW'(col_s1);
		neg_s2 <= neg_s1;
		gy_s2  <= gy_s1;
		d_s3   <= AW'(n_q - NW'(p_s2));
		neg_s3 <= neg_s2;
		gy_s3  <= gy_s2;
		neg_s4 <= neg_s3;
		gy_s4  <= gy_s3;
	end

	assign raddr_w = (wp_q >= d_s3) ? {1'b0, wp_q} - {1'b0, d_s3}
		: {1'b0, wp_q} + (AW+1)'(DEPTH) - {1'b0, d_s3};
	assign raddr   = raddr_w[AW-1:0];

	pem_ram #(
		.WIDTH ($bits(pem_pkg::pix_t)),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (wp_q),
		.wdata (pix_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// kernel sums, squares and root
	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			logic [CW-1:0]        byte_v;
			logic signed [GW-1:0] val_v;
			logic [GW-2:0]        ax_v, ay_v;
			logic [MW:0]          sum_v;
			logic [CW-1:0]        tr_v;
			byte_v = (c == 0) ? rdata.blue : ((c == 1) ? rdata.green : rdata.red);
			val_v  = signed'(GW'(byte_v));
			ax_v   = (gx_q[c] < 0) ? (GW-1)'(-gx_q[c]) : (GW-1)'(gx_q[c]);
			ay_v   = (gy_q[c] < 0) ? (GW-1)'(-gy_q[c]) : (GW-1)'(gy_q[c]);
			sum_v  = (MW+1)'(sqx_q[c]) + (MW+1)'(sqy_q[c]);
			tr_v   = root_q[c] | (CW'(1) << bit_q);
			if (cmd.rd_start) begin
				gx_q[c] <= '0;
				gy_q[c] <= '0;
			end else if (vld_s4) begin
				if (gy_s4) begin
					gy_q[c] <= neg_s4 ? gy_q[c] - val_v : gy_q[c] + val_v;
				end else begin
					gx_q[c] <= neg_s4 ? gx_q[c] - val_v : gx_q[c] + val_v;
				end
			end
			if (cmd.sq_square) begin
				sqx_q[c] <= MW'(ax_v * ax_v);
				sqy_q[c] <= MW'(ay_v * ay_v);
			end
			if (cmd.sq_sum) begin
				s_q[c]    <= sum_v[15:0];
				sat_q[c]  <= ((sum_v >> 16) != '0);
				root_q[c] <= '0;
			end else if (cmd.sq_step) begin
				if (16'(tr_v) * 16'(tr_v) <= s_q[c]) begin
					root_q[c] <= tr_v;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (cmd.sq_sum) begin
			bit_q <= 3'd7;
		end else if (cmd.sq_step) begin
			bit_q <= bit_q - 3'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ob_q    <= sat_q[0] ? pem_pkg::CHAN_MAX : root_q[0];
			og_q    <= sat_q[1] ? pem_pkg::CHAN_MAX : root_q[1];
			or_q    <= sat_q[2] ? pem_pkg::CHAN_MAX : root_q[2];
			olast_q <= last_pix;
		end
	end

	assign out_valid  = out_vld_q;
	assign out_blue   = ob_q;
	assign out_green  = og_q;
	assign out_red    = or_q;
	assign frame_last = olast_q;

	assign st.in_frame  = (n_q < total_q);
	assign st.flush     = flush_q;
	assign st.has_out   = (n_q >= delay_q);
	assign st.rd_last   = (seg_q == 2'd3) && (t_q == r_sig);
	assign st.pipe_busy = vld_s1 | vld_s2 | vld_s3 | vld_s4;
	assign st.root_last = (bit_q == 3'd0);
	assign st.out_free  = !out_vld_q || out_ready;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the RGB Prewitt edge magnitude block.
`timescale 1ns / 100ps

module testbench;

	localparam int STORE_DEPTH = pem_pkg::DEF_MAX_KERNEL * pem_pkg::DEF_MAX_WIDTH;
	localparam int DRAIN_CYCLES = 4 * pem_pkg::DEF_MAX_KERNEL + 18 + 20;
	localparam int STALL_LIMIT = 4000;
	localparam int ITEM_TARGET = 550;
	localparam int CW = pem_pkg::CHAN_W;
	localparam int CFGW = pem_pkg::CFG_W;

	typedef struct packed {
		logic [CW-1:0] blue;
		logic [CW-1:0] green;
		logic [CW-1:0] red;
		logic          last;
	} mag_t;

	logic clk;
	logic arst_n;
	logic cfg_wen;
	pem_pkg::reg_idx_t cfg_index;
	logic [CFGW-1:0] cfg_data;

	pem_in_if pix ();
	pem_out_if mag ();

	prewitt_edge_magnitude_rgb i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixels     (pix.sink),
		.magnitudes (mag.source)
	);

	pem_pkg::pix_t line_store [STORE_DEPTH];
	int unsigned   pixel_index;
	logic [CFGW-1:0]             width_reg;
	logic [CFGW-1:0]             height_reg;
	logic [pem_pkg::KSIZE_W-1:0] ksize_reg;
	bit          frame_closed;
	mag_t        pending_mags [$];
	int          error_count;
	int          items_sent;
	int          idle_cycles = 0;
	bit          calm;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic report(input string what);
		$display("error at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic int width_eff();
		if (width_reg == 0) return 1;
		if (width_reg > pem_pkg::DEF_MAX_WIDTH) return pem_pkg::DEF_MAX_WIDTH;
		return int'(width_reg);
	endfunction

	function automatic int height_eff();
		if (height_reg == 0) return 1;
		if (height_reg > pem_pkg::DEF_MAX_HEIGHT) return pem_pkg::DEF_MAX_HEIGHT;
		return int'(height_reg);
	endfunction

	function automatic int ksize_eff();
		int k;
		k = int'(ksize_reg);
		if (k > pem_pkg::DEF_MAX_KERNEL) k = pem_pkg::DEF_MAX_KERNEL;
		if (k % 2 == 0 && k > 0) k = k - 1;
		if (k < 3) k = 3;
		return k;
	endfunction

	function automatic int fetch_chan(int row, int col, int w, int h, int ch);
		pem_pkg::pix_t p;
		if (row < 0) row = 0;
		if (row > h - 1) row = h - 1;
		if (col < 0) col = 0;
		if (col > w - 1) col = w - 1;
		p = line_store[(row * w + col) % STORE_DEPTH];
		case (ch)
			0: return int'(p.blue);
			1: return int'(p.green);
			default: return int'(p.red);
		endcase
	endfunction

	function automatic logic [CW-1:0] root_sat(int gx, int gy);
		int s;
		int root;
		s = gx * gx + gy * gy;
		if (s >= 65536) return pem_pkg::CHAN_MAX;
		root = 0;
		for (int b = 128; b != 0; b = b >> 1)
			if ((root | b) * (root | b) <= s) root = root | b;
		return root[CW-1:0];
	endfunction

	// advance the frame by one accepted transaction
	function automatic void predict_magnitude(logic cmd, pem_pkg::pix_t px);
		int w, h, k, r, total, lag, n, o, row, col, gx, gy;
		logic [CW-1:0] mags [3];
		mag_t m;
		w = width_eff();
		h = height_eff();
		k = ksize_eff();
		r = (k - 1) / 2;
		total = w * h;
		lag = r * w + r;
		n = int'(pixel_index);
		if (n < total) begin
			if (cmd == pem_pkg::CMD_FLUSH) return;
			line_store[n % STORE_DEPTH] = px;
		end
		if (n < lag) begin
			pixel_index++;
			return;
		end
		o = n - lag;
		if (o >= total) begin
			pixel_index = 0;
			return;
		end
		row = o / w;
		col = o % w;
		for (int ch = 0; ch < 3; ch++) begin
			gx = 0;
			gy = 0;
			for (int t = -r; t <= r; t++) begin
				gx += fetch_chan(row + t, col + r, w, h, ch);
				gx -= fetch_chan(row + t, col - r, w, h, ch);
				gy += fetch_chan(row + r, col + t, w, h, ch);
				gy -= fetch_chan(row - r, col + t, w, h, ch);
			end
			mags[ch] = root_sat(gx, gy);
		end
		m.blue = mags[0];
		m.green = mags[1];
		m.red = mags[2];
		m.last = (o == total - 1);
		pending_mags.push_back(m);
		if (m.last) begin
			pixel_index = 0;
			frame_closed = 1'b1;
		end else begin
			pixel_index++;
		end
	endfunction

	task automatic send_item(input logic cmd, input pem_pkg::pix_t px);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.cmd <= cmd;
		pix.in_blue <= px.blue;
		pix.in_green <= px.green;
		pix.in_red <= px.red;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		predict_magnitude(cmd, px);
		items_sent++;
	endtask

	task automatic wait_drained();
		pix.valid <= 1'b0;
		while (pending_mags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input pem_pkg::reg_idx_t idx, input logic [CFGW-1:0] value);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			pem_pkg::REG_FRAME_WIDTH: width_reg = value;
			pem_pkg::REG_FRAME_HEIGHT: height_reg = value;
			default: ksize_reg = value[pem_pkg::KSIZE_W-1:0];
		endcase
		pixel_index = 0;
	endtask

	task automatic set_frame(input int w, input int h, input int k);
		write_reg(pem_pkg::REG_FRAME_WIDTH, CFGW'(w));
		write_reg(pem_pkg::REG_FRAME_HEIGHT, CFGW'(h));
		write_reg(pem_pkg::REG_KERNEL_SIZE, CFGW'(k));
	endtask

	function automatic pem_pkg::pix_t draw_pixel(input bit extremes);
		pem_pkg::pix_t p;
		p.blue = CW'($urandom_range(0, 255));
		p.green = CW'($urandom_range(0, 255));
		p.red = CW'($urandom_range(0, 255));
		if (extremes) begin
			p.blue = ($urandom_range(0, 1) == 1) ? pem_pkg::CHAN_MAX : '0;
			p.green = ($urandom_range(0, 1) == 1) ? pem_pkg::CHAN_MAX : '0;
			p.red = ($urandom_range(0, 1) == 1) ? pem_pkg::CHAN_MAX : '0;
		end
		return p;
	endfunction

	// send a whole frame (stray flushes when noisy), then drain with flushes (or dropped pixels when noisy)
	task automatic run_frame(input bit extremes, input bit noisy);
		int pixels_left;
		pixels_left = width_eff() * height_eff();
		frame_closed = 1'b0;
		while (!frame_closed) begin
			if (pixels_left > 0) begin
				if (noisy && $urandom_range(0, 9) == 0) begin
					send_item(pem_pkg::CMD_FLUSH, draw_pixel(1'b0));
				end else begin
					send_item(pem_pkg::CMD_PIXEL, draw_pixel(extremes));
					pixels_left--;
				end
			end else begin
				send_item((noisy && $urandom_range(0, 3) == 0) ? pem_pkg::CMD_PIXEL
					: pem_pkg::CMD_FLUSH, draw_pixel(1'b0));
			end
		end
	endtask

	task automatic test_small_frames();
		set_frame(4, 3, 3);
		run_frame(1'b1, 1'b1);
		set_frame(1, 1, 7);
		run_frame(1'b1, 1'b0);
		set_frame(5, 4, 5);
		run_frame(1'b0, 1'b1);
	endtask

	task automatic test_kernel_codes();
		set_frame(4, 3, 0);
		for (int k = 0; k < 8; k++) begin
			write_reg(pem_pkg::REG_KERNEL_SIZE, CFGW'(k));
			run_frame(1'(k % 2), 1'b1);
		end
	endtask

	task automatic test_size_limits();
		calm = 1'b1;
		set_frame(0, 0, 3);
		run_frame(1'b1, 1'b1);
		set_frame(2047, 2, 3);
		repeat (40) send_item(pem_pkg::CMD_PIXEL, draw_pixel(1'b1));
		set_frame(1, 2047, 7);
		repeat (40) send_item(pem_pkg::CMD_PIXEL, draw_pixel(1'b1));
		calm = 1'b0;
	endtask

	task automatic test_abandoned_frame();
		set_frame(7, 6, 3);
		repeat (20) send_item(pem_pkg::CMD_PIXEL, draw_pixel(1'b0));
		write_reg(pem_pkg::REG_FRAME_HEIGHT, CFGW'(3));
		run_frame(1'b0, 1'b1);
	endtask

	task automatic test_random_frames();
		while (items_sent < ITEM_TARGET) begin
			calm = ($urandom_range(0, 3) == 0);
			set_frame($urandom_range(1, 12), $urandom_range(1, 8), $urandom_range(0, 7));
			run_frame($urandom_range(0, 2) == 0, $urandom_range(0, 1) == 1);
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = pem_pkg::REG_FRAME_WIDTH;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.cmd = pem_pkg::CMD_PIXEL;
		pix.in_blue = '0;
		pix.in_green = '0;
		pix.in_red = '0;
		width_reg = pem_pkg::RESET_FRAME_WIDTH;
		height_reg = pem_pkg::RESET_FRAME_HEIGHT;
		ksize_reg = pem_pkg::RESET_KERNEL_SIZE;
		pixel_index = 0;
		error_count = 0;
		items_sent = 0;
		calm = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_small_frames();
		test_kernel_codes();
		test_size_limits();
		test_abandoned_frame();
		test_random_frames();
		wait_drained();
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hold ready low for a random stall before each result, unless calm
	initial begin
		int stall;
		mag.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				mag.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			mag.ready <= 1'b1;
			@(posedge clk);
			while (!(mag.valid && mag.ready)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		mag_t want;
		if (arst_n && mag.valid && mag.ready) begin
			if (pending_mags.size() == 0) begin
				report("result transaction with nothing expected");
			end else begin
				want = pending_mags.pop_front();
				if (mag.out_blue !== want.blue)
					report($sformatf("out_blue %0d, want %0d", mag.out_blue, want.blue));
				if (mag.out_green !== want.green)
					report($sformatf("out_green %0d, want %0d", mag.out_green, want.green));
				if (mag.out_red !== want.red)
					report($sformatf("out_red %0d, want %0d", mag.out_red, want.red));
				if (mag.frame_last !== want.last)
					report($sformatf("frame_last %0b, want %0b", mag.frame_last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (mag.valid && mag.ready) || cfg_wen || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

@@ prewitt_edge_magnitude_rgb.f @@
rtl/core/pem_pkg.sv
rtl/core/pem_if.sv
rtl/core/pem_ram.sv
rtl/core/pem_ctrl.sv
rtl/core/pem_dp.sv
rtl/core/prewitt_edge_magnitude_rgb.sv
bench/testbench.sv
